### rtl/cfrc_pkg.sv
// Shared types and constants of the chunk frame reassembly checker.
package cfrc_pkg;

    // Field widths fixed by the chunk header and the status record.
    localparam int FRAME_ID_W = 8;
    localparam int ID_W       = 16;
    localparam int FLAG_W     = 8;
    localparam int PAYLOAD_W  = 14;
    localparam int BYTES_W    = 20;
    localparam int STATUS_W   = 4;
    localparam int NUMBER_W   = 32;
    localparam int CODE_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOF = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [CODE_W-1:0] SOF_RESET = 2'd1;
    localparam logic [CODE_W-1:0] EOF_RESET = 2'd2;

    // Highest flag value that may be recorded.
    localparam logic [FLAG_W-1:0] FLAG_MAX = 8'd2;

    // Bit positions in the status field.
    localparam int ST_CHUNK_ERR = 0;
    localparam int ST_SIZE_ERR  = 1;
    localparam int ST_NO_SOF    = 2;
    localparam int ST_NO_EOF    = 3;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // One parsed chunk header.
    typedef struct packed {
        logic [FRAME_ID_W-1:0] frame_id;
        logic [ID_W-1:0]       seq_id;
        logic [FLAG_W-1:0]     chunk_flag;
        logic                  header_valid;
        logic [PAYLOAD_W-1:0]  payload_bytes;
    } in_item_t;

    // One frame status record.
    typedef struct packed {
        logic [FRAME_ID_W-1:0] done_frame_id;
        logic [BYTES_W-1:0]    frame_bytes;
        logic [STATUS_W-1:0]   status_bits;
        logic [NUMBER_W-1:0]   frame_number;
    } out_item_t;

    // Configuration register contents.
    typedef struct packed {
        logic [CODE_W-1:0] sof_code;
        logic [CODE_W-1:0] eof_code;
    } cfg_t;

    // A classified chunk as it waits in the queue.
    typedef struct packed {
        logic [FRAME_ID_W-1:0] frame_id;
        logic [ID_W-1:0]       seq_id;
        logic [CODE_W-1:0]     flag;
        logic                  eligible;
        logic                  eof_hit;
        logic [PAYLOAD_W-1:0]  payload_bytes;
    } work_t;

endpackage

### rtl/chunk_frame_reassembly_checker.sv
// Top level of the chunk frame reassembly checker.
//
//   Channel | Direction | Handshake          | Contents
//   in      | input     | in_valid/in_stall   | one chunk header (in_item_t)
//   out     | output    | out_valid/out_stall | one frame status record (out_item_t)
//   cfg     | input     | cfg_valid/cfg_ready | register index and write data
//
// The back end reads the frame record memory in S_IDLE as it pops a request, and in
// S_CALC updates it and loads the result register before it pops again, on its single
// record memory port pair. A header is taken while the two-entry queue has room.
// Reset clears the per-frame valid bits at once, so no clearing pass follows it.
// While out_stall holds a result, a closing chunk waits in the back end and the
// queue fills, after which in_stall rises.
module chunk_frame_reassembly_checker import cfrc_pkg::*; #(
    parameter int FRAME_IDS  = 256,
    parameter int MAX_CHUNKS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  push, pop, q_full, q_empty;
    work_t push_data, q_head;

    // Configuration registers; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SOF: cfg_next.sof_code = cfg_data;
                REG_EOF: cfg_next.eof_code = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_code <= SOF_RESET;
            cfg_reg.eof_code <= EOF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cfrc_front #(
        .FRAME_IDS(FRAME_IDS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_data(push_data)
    );

    cfrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    cfrc_back #(
        .FRAME_IDS (FRAME_IDS),
        .MAX_CHUNKS(MAX_CHUNKS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

### rtl/cfrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array and read register; neither needs a reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/cfrc_front.sv
// Front end: accepts chunk headers, classifies them and pushes them to the queue.
module cfrc_front import cfrc_pkg::*; #(
    parameter int FRAME_IDS = 256
) (
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     push,
    output work_t    push_data
);

    logic in_range;

    // Frame ids beyond the table are taken and then dropped.
    assign in_range = {1'b0, in_data.frame_id} < (FRAME_ID_W + 1)'(FRAME_IDS);

    // The front end waits only for room in the queue.
    assign in_stall = q_full;
    assign push     = in_valid && !q_full && in_range;

    // Classify the header: may it be recorded, and does it close its frame?
    always_comb
    begin
        push_data.frame_id      = in_data.frame_id;
        push_data.seq_id        = in_data.seq_id;
        push_data.flag          = in_data.chunk_flag[CODE_W-1:0];
        push_data.eligible      = in_data.header_valid && (in_data.chunk_flag <= FLAG_MAX);
        push_data.eof_hit       = in_data.chunk_flag == FLAG_W'(cfg.eof_code);
        push_data.payload_bytes = in_data.payload_bytes;
    end

endmodule

### rtl/cfrc_queue.sv
// Short queue of classified chunks between the front and back ends.
module cfrc_queue import cfrc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/cfrc_back.sv
// Back end: per-frame bookkeeping, frame check and the status record register.
module cfrc_back import cfrc_pkg::*; #(
    parameter int FRAME_IDS  = 256,
    parameter int MAX_CHUNKS = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  work_t     q_head,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int FRAME_W = (FRAME_IDS > 1) ? $clog2(FRAME_IDS) : 1;
    localparam int CNT_W   = $clog2(MAX_CHUNKS);
    localparam int IDX_W   = $clog2(MAX_CHUNKS);

    // Everything kept for one frame id.
    typedef struct packed {
        logic [MAX_CHUNKS-1:0] seen;
        logic [CNT_W-1:0]      count;
        logic [BYTES_W-1:0]    bytes;
        logic [ID_W-1:0]       low_id;
        logic [CODE_W-1:0]     low_flag;
        logic [ID_W-1:0]       high_id;
        logic [CODE_W-1:0]     high_flag;
        logic                  dup;
    } frame_rec_t;

    localparam int REC_W = $bits(frame_rec_t);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t                 state_reg, state_next;
    work_t                  item_reg, item_next;
    logic [FRAME_IDS-1:0]   live_reg, live_next;
    logic [NUMBER_W-1:0]    done_count_reg, done_count_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;

    logic                   rd_en;
    logic [REC_W-1:0]       rd_data;
    logic                   wr_en;
    frame_rec_t             rec_cur, rec_new, rec_reset;
    logic [FRAME_W-1:0]     fidx;
    logic [IDX_W-1:0]       sidx;
    logic                   record_ok, id_small, trigger, out_free;
    logic                   no_sof, no_eof, id_err;
    logic [ID_W-1:0]        last_id;
    logic [STATUS_W-1:0]    status;

    // Frame record store, one row per frame id.
    cfrc_ram #(
        .WIDTH(REC_W),
        .DEPTH(FRAME_IDS)
    ) u_rec_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(fidx),
        .wr_data(rec_new),
        .rd_en  (rd_en),
        .rd_addr(q_head.frame_id[FRAME_W-1:0]),
        .rd_data(rd_data)
    );

    assign fidx     = item_reg.frame_id[FRAME_W-1:0];
    assign sidx     = item_reg.seq_id[IDX_W-1:0];
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign rd_en    = q_pop;
    assign out_free = !out_valid_reg || !out_stall;

    // Update of the frame record with the current chunk.
    always_comb
    begin
        rec_reset        = '0;
        rec_reset.low_id = '1;
        rec_cur          = live_reg[fidx] ? frame_rec_t'(rd_data) : rec_reset;
        record_ok        = item_reg.eligible && (rec_cur.count < CNT_W'(MAX_CHUNKS - 1));
        id_small         = item_reg.seq_id < ID_W'(MAX_CHUNKS);
        rec_new          = rec_cur;
        if (record_ok)
        begin
            if (id_small)
            begin
                rec_new.dup       = rec_cur.dup || rec_cur.seen[sidx];
                rec_new.seen[sidx] = 1'b1;
            end
            if ((rec_cur.count == '0) || (item_reg.seq_id < rec_cur.low_id))
            begin
                rec_new.low_id   = item_reg.seq_id;
                rec_new.low_flag = item_reg.flag;
            end
            if ((rec_cur.count == '0) || (item_reg.seq_id >= rec_cur.high_id))
            begin
                rec_new.high_id   = item_reg.seq_id;
                rec_new.high_flag = item_reg.flag;
            end
            rec_new.count = rec_cur.count + 1'b1;
            rec_new.bytes = rec_cur.bytes + BYTES_W'(item_reg.payload_bytes);
        end
    end

    // Frame check on the updated record.
    always_comb
    begin
        trigger = item_reg.eof_hit && (rec_new.count != '0);
        no_sof  = rec_new.low_flag != cfg.sof_code;
        no_eof  = rec_new.high_flag != cfg.eof_code;
        last_id = ID_W'(rec_new.count) - ID_W'(1);
        id_err  = rec_new.dup || (rec_new.low_id != '0) || (rec_new.high_id != last_id);
        status                = '0;
        status[ST_CHUNK_ERR]  = id_err || no_sof || no_eof;
        status[ST_SIZE_ERR]   = rec_new.bytes[1:0] != 2'b00;
        status[ST_NO_SOF]     = no_sof;
        status[ST_NO_EOF]     = no_eof;
    end

    assign wr_en = (state_reg == S_CALC) && !trigger && record_ok;

    // Sequencer and result register.
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        live_next       = live_reg;
        done_count_next = done_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    item_next  = q_head;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (trigger)
                begin
                    // A closing chunk waits until the result register is free.
                    if (out_free)
                    begin
                        live_next[fidx]             = 1'b0;
                        done_count_next             = done_count_reg + 1'b1;
                        out_valid_next              = 1'b1;
                        out_data_next.done_frame_id = item_reg.frame_id;
                        out_data_next.frame_bytes   = rec_new.bytes;
                        out_data_next.status_bits   = status;
                        out_data_next.frame_number  = done_count_reg;
                        state_next                  = S_IDLE;
                    end
                end
                else
                begin
                    if (record_ok)
                    begin
                        live_next[fidx] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_reg       <= '0;
            done_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_reg       <= live_next;
            done_count_reg <= done_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/cfrc_checker.sv
// Port-level assertions for the chunk frame reassembly checker, with their bind.
module cfrc_checker import cfrc_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled status record stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled status record changed");

    // A missing start or end flag always counts as a chunk error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status_bits[ST_NO_SOF] || out_data.status_bits[ST_NO_EOF])
        |-> out_data.status_bits[ST_CHUNK_ERR])
        else $error("start or end flag missing without chunk error");

    // The size flag follows the low two bits of the byte total.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status_bits[ST_SIZE_ERR] == (out_data.frame_bytes[1:0] != 2'b00)))
        else $error("size flag disagrees with frame byte total");

endmodule

bind chunk_frame_reassembly_checker cfrc_checker u_cfrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

### test/tb_chunk_frame_reassembly_checker.sv
// Testbench of the chunk frame reassembly checker: random chunk streams checked against a scoreboard.
`timescale 1ns / 100ps

module tb_chunk_frame_reassembly_checker;
    import cfrc_pkg::*;

    localparam int FRAME_COUNT   = 256;
    localparam int CHUNK_LIMIT   = 128;
    localparam int CNT_W         = $clog2(CHUNK_LIMIT);
    localparam int PAYLOAD_TOP   = 9000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 325;

    // Register indexes that the block does not implement.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Flag values used by the directed requests; start and end follow the reset codes.
    localparam logic [FLAG_W-1:0] FLAG_SOF = FLAG_W'(SOF_RESET);
    localparam logic [FLAG_W-1:0] FLAG_EOF = FLAG_W'(EOF_RESET);
    localparam logic [FLAG_W-1:0] FLAG_MID = 8'd0;
    localparam logic [FLAG_W-1:0] FLAG_TOP = 8'd255;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]    cfg_data  = '0;

    int in_idle_pct  = 0;
    int out_idle_pct = 0;

    // Per-frame bookkeeping mirrored from the block, plus the records still owed.
    class frame_record_board;
        bit [CODE_W-1:0]      sof_code;
        bit [CODE_W-1:0]      eof_code;
        bit [CNT_W-1:0]       chunk_cnt [FRAME_COUNT];
        bit [BYTES_W-1:0]     byte_sum  [FRAME_COUNT];
        bit [CHUNK_LIMIT-1:0] id_seen   [FRAME_COUNT];
        bit [ID_W-1:0]        low_id    [FRAME_COUNT];
        bit [CODE_W-1:0]      low_flag  [FRAME_COUNT];
        bit [ID_W-1:0]        high_id   [FRAME_COUNT];
        bit [CODE_W-1:0]      high_flag [FRAME_COUNT];
        bit                   dup_id    [FRAME_COUNT];
        bit [NUMBER_W-1:0]    frames_closed;
        out_item_t            pending_records[$];
        int                   errors;

        function void wipe_frame(int f);
            chunk_cnt[f] = '0;
            byte_sum[f]  = '0;
            id_seen[f]   = '0;
            low_id[f]    = '1;
            low_flag[f]  = '0;
            high_id[f]   = '0;
            high_flag[f] = '0;
            dup_id[f]    = 1'b0;
        endfunction

        function void reset_state();
            sof_code      = SOF_RESET;
            eof_code      = EOF_RESET;
            frames_closed = '0;
            errors        = 0;
            for (int f = 0; f < FRAME_COUNT; f++)
                wipe_frame(f);
        endfunction

        function void set_code(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] value);
            if (idx == REG_SOF)
                sof_code = value;
            else if (idx == REG_EOF)
                eof_code = value;
        endfunction

        // Record the chunk if it qualifies, and owe a status record when it closes its frame.
        function void note_chunk(in_item_t c);
            int        f;
            bit        no_sof;
            bit        no_eof;
            bit        id_err;
            out_item_t rec;
            f = c.frame_id;
            if (chunk_cnt[f] < CNT_W'(CHUNK_LIMIT - 1) && c.header_valid &&
                c.chunk_flag <= FLAG_MAX)
            begin
                if (c.seq_id < CHUNK_LIMIT)
                begin
                    if (id_seen[f][c.seq_id])
                        dup_id[f] = 1'b1;
                    id_seen[f][c.seq_id] = 1'b1;
                end
                // The lowest entry keeps the first of equal ids, the highest the last.
                if (chunk_cnt[f] == 0 || c.seq_id < low_id[f])
                begin
                    low_id[f]   = c.seq_id;
                    low_flag[f] = c.chunk_flag[CODE_W-1:0];
                end
                if (chunk_cnt[f] == 0 || c.seq_id >= high_id[f])
                begin
                    high_id[f]   = c.seq_id;
                    high_flag[f] = c.chunk_flag[CODE_W-1:0];
                end
                chunk_cnt[f] = chunk_cnt[f] + 1'b1;
                byte_sum[f]  = byte_sum[f] + BYTES_W'(c.payload_bytes);
            end
            if (c.chunk_flag != FLAG_W'(eof_code) || chunk_cnt[f] == 0)
                return;
            no_sof = low_flag[f] != sof_code;
            no_eof = high_flag[f] != eof_code;
            id_err = dup_id[f] || low_id[f] != '0 ||
                     high_id[f] != ID_W'(chunk_cnt[f]) - 1'b1;
            rec.done_frame_id             = c.frame_id;
            rec.frame_bytes               = byte_sum[f];
            rec.status_bits               = '0;
            rec.status_bits[ST_CHUNK_ERR] = id_err || no_sof || no_eof;
            rec.status_bits[ST_SIZE_ERR]  = byte_sum[f][1:0] != 2'b00;
            rec.status_bits[ST_NO_SOF]    = no_sof;
            rec.status_bits[ST_NO_EOF]    = no_eof;
            rec.frame_number              = frames_closed;
            frames_closed++;
            pending_records.push_back(rec);
            wipe_frame(f);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare a status record from the block with the oldest one owed.
        function void check_record(out_item_t r);
            out_item_t want;
            if (pending_records.size() == 0)
            begin
                $error("status record for frame %0d with none expected", r.done_frame_id);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            compare_field("done_frame_id", want.done_frame_id, r.done_frame_id);
            compare_field("frame_bytes", want.frame_bytes, r.frame_bytes);
            compare_field("status_bits", want.status_bits, r.status_bits);
            compare_field("frame_number", want.frame_number, r.frame_number);
        endfunction
    endclass

    frame_record_board board;

    chunk_frame_reassembly_checker #(
        .FRAME_IDS  (FRAME_COUNT),
        .MAX_CHUNKS (CHUNK_LIMIT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Result side: check every accepted record and stall at random.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_record(out_data);
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    // Offer one chunk header until it is taken, then idle at random.
    task automatic send_chunk(in_item_t c);
        in_valid <= 1'b1;
        in_data  <= c;
        do
            @(posedge clk);
        while (in_stall);
        board.note_chunk(c);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_header(logic [FRAME_ID_W-1:0] fid, logic [ID_W-1:0] id,
                               logic [FLAG_W-1:0] flag, logic hv, logic [PAYLOAD_W-1:0] bytes);
        in_item_t c;
        c.frame_id      = fid;
        c.seq_id        = id;
        c.chunk_flag    = flag;
        c.header_valid  = hv;
        c.payload_bytes = bytes;
        send_chunk(c);
    endtask

    // Hold the sender until every owed record has arrived and the back end has settled.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_code(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_code(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Build a well-formed frame of n chunks in random order, closing chunk last,
    // and sometimes damage it.
    task automatic build_frame(input logic [FRAME_ID_W-1:0] fid, input int n, input bit heavy,
                               ref in_item_t q[$]);
        in_item_t          c;
        logic [CODE_W-1:0] mid;
        int                i;
        int                k;
        int                j;
        q.delete();
        do
            mid = CODE_W'($urandom_range(0, 2));
        while (mid == board.eof_code);
        for (i = 0; i < n; i++)
        begin
            c.frame_id     = fid;
            c.seq_id       = ID_W'(i);
            c.chunk_flag   = FLAG_W'((i == 0) ? board.sof_code : mid);
            if (i == n - 1)
                c.chunk_flag = FLAG_W'(board.eof_code);
            c.header_valid = 1'b1;
            if (heavy)
                c.payload_bytes = PAYLOAD_W'($urandom_range(8000, PAYLOAD_TOP));
            else
                c.payload_bytes = PAYLOAD_W'(4 * $urandom_range(0, PAYLOAD_TOP / 4));
            q.push_back(c);
        end
        for (k = n - 2; k > 0; k--)
        begin
            j    = $urandom_range(0, k);
            c    = q[k];
            q[k] = q[j];
            q[j] = c;
        end
        if (n == 0 || $urandom_range(0, 3) != 0)
            return;
        k = $urandom_range(0, q.size() - 1);
        c = q[k];
        case ($urandom_range(0, 7))
            0: q.delete(k);
            1: q.insert(k, c);
            2:
            begin
                c.header_valid = 1'b0;
                q[k] = c;
            end
            3:
            begin
                c.chunk_flag = FLAG_W'($urandom_range(3, 255));
                q[k] = c;
            end
            4:
            begin
                c.seq_id = ID_W'($urandom);
                q[k] = c;
            end
            5:
            begin
                c.payload_bytes = PAYLOAD_W'($urandom_range(0, PAYLOAD_TOP));
                q[k] = c;
            end
            6: void'(q.pop_back());
            default:
            begin
                q[k] = q[q.size() - 1];
                q[q.size() - 1] = c;
            end
        endcase
    endtask

    // One or two frames interleaved, with stray headers mixed in.
    task automatic run_batch(input bit heavy, inout int sent);
        in_item_t              qa[$];
        in_item_t              qb[$];
        in_item_t              c;
        logic [FRAME_ID_W-1:0] fa;
        logic [FRAME_ID_W-1:0] fb;
        int                    na;
        int                    nb;
        fa = FRAME_ID_W'($urandom);
        do
            fb = FRAME_ID_W'($urandom);
        while (fb == fa);
        if (heavy)
            na = CHUNK_LIMIT + 2;
        else if ($urandom_range(0, 7) == 0)
            na = $urandom_range(9, 24);
        else
            na = $urandom_range(1, 8);
        nb = (heavy || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        build_frame(fa, na, heavy, qa);
        build_frame(fb, nb, 1'b0, qb);
        while (qa.size() + qb.size() != 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                c.frame_id      = FRAME_ID_W'($urandom);
                c.seq_id        = ID_W'($urandom);
                c.chunk_flag    = FLAG_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 3));
                c.header_valid  = 1'($urandom);
                c.payload_bytes = PAYLOAD_W'($urandom_range(0, PAYLOAD_TOP));
            end
            else if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1))
                c = qa.pop_front();
            else
                c = qb.pop_front();
            send_chunk(c);
            sent++;
        end
    endtask

    // Stimulus: directed frames under reset codes, then random phases.
    initial
    begin
        int                sent;
        bit [CODE_W-1:0]   sof_plan [PHASES];
        bit [CODE_W-1:0]   eof_plan [PHASES];
        sof_plan = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd2};
        eof_plan = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd0, 2'd2};
        board = new();
        board.reset_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A clean frame, then one out of order with odd sizes at the payload extremes.
        send_header(8'd5, 16'd0, FLAG_SOF, 1'b1, 14'd100);
        send_header(8'd5, 16'd1, FLAG_MID, 1'b1, 14'd8);
        send_header(8'd5, 16'd2, FLAG_EOF, 1'b1, 14'd0);
        send_header(8'd255, 16'd1, FLAG_MID, 1'b1, 14'd9000);
        send_header(8'd255, 16'd0, FLAG_SOF, 1'b1, 14'd3);
        send_header(8'd255, 16'd2, FLAG_EOF, 1'b1, 14'd1);
        // Repeated chunk id.
        send_header(8'd7, 16'd0, FLAG_SOF, 1'b1, 14'd4);
        send_header(8'd7, 16'd0, FLAG_MID, 1'b1, 14'd4);
        send_header(8'd7, 16'd1, FLAG_EOF, 1'b1, 14'd4);
        // Chunks left out: bad header, flags out of range; then a lone closing chunk.
        send_header(8'd9, 16'd0, FLAG_SOF, 1'b0, 14'd16);
        send_header(8'd9, 16'd0, FLAG_TOP, 1'b1, 14'd16);
        send_header(8'd9, 16'd0, FLAG_MAX + 1'b1, 1'b1, 14'd16);
        send_header(8'd9, 16'd0, FLAG_EOF, 1'b1, 14'd16);
        // End code on an empty frame gives nothing.
        send_header(8'd11, 16'd0, FLAG_EOF, 1'b0, 14'd0);
        // Chunk id far beyond the chunk limit.
        send_header(8'd12, 16'd0, FLAG_SOF, 1'b1, 14'd12);
        send_header(8'd12, 16'd65535, FLAG_EOF, 1'b1, 14'd12);
        // Lowest id missing.
        send_header(8'd0, 16'd1, FLAG_SOF, 1'b1, 14'd4);
        send_header(8'd0, 16'd2, FLAG_EOF, 1'b1, 14'd4);
        // End code on a chunk below the highest id.
        send_header(8'd14, 16'd0, FLAG_SOF, 1'b1, 14'd4);
        send_header(8'd14, 16'd2, FLAG_MID, 1'b1, 14'd4);
        send_header(8'd14, 16'd1, FLAG_EOF, 1'b1, 14'd4);

        for (int p = 0; p < PHASES; p++)
        begin
            // Codes change only once the block has gone quiet.
            wait_drained();
            if (p == 0)
            begin
                program_code(REG_SPARE_LO, CODE_W'($urandom));
                program_code(REG_SPARE_HI, CODE_W'($urandom));
            end
            program_code(REG_SOF, sof_plan[p]);
            program_code(REG_EOF, eof_plan[p]);
            if (p < 2)
            begin
                in_idle_pct  = 29;
                out_idle_pct = 59;
            end
            else if (p < 4)
            begin
                in_idle_pct  = 59;
                out_idle_pct = 29;
            end
            else
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            sent = 0;
            // An overlong frame that fills the chunk table and wraps the byte total.
            if (p == 0 || p == 3)
                run_batch(1'b1, sent);
            while (sent < PHASE_ITEMS)
                run_batch(1'b0, sent);
        end

        wait_drained();
        if (board.errors == 0 && board.pending_records.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
